// ===== rtl/tbar_pkg.sv =====
// Package for the two-background alpha recovery block.
// Holds the divider cell payload type and the fixed-point constants.
// No dependencies.
package tbar_pkg;

   localparam int NUM_CH       = 3;
   localparam int PIX_W        = 8;
   localparam int SUM_W        = 10;
   localparam int REM_W        = 17;
   localparam int QUO_W        = 9;
   localparam int DEN_W        = 9;
   localparam int RECIP3       = 683;
   localparam int RECIP3_W     = 10;
   localparam int RECIP3_SHIFT = 11;
   localparam int PROD_W       = SUM_W + RECIP3_W;

   localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;
   localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;

   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;

   typedef logic [PIX_W-1:0] pix_type;

   // Word handed from cell to cell along the divider chain.
   typedef struct packed {
      logic [NUM_CH-1:0][REM_W-1:0] rem;
      logic [NUM_CH-1:0][QUO_W-1:0] quo;
      logic [DEN_W-1:0]             den;
      logic [NUM_CH-1:0][PIX_W-1:0] black;
      logic [PIX_W-1:0]             alpha;
      logic                         invalid;
      logic                         last;
   } div_type;

endpackage

// ===== rtl/tbar_front.sv =====
// Front end of the alpha recovery pipeline: channel alpha, average, divider setup.
// Three register stages; produces the first word of the divider chain.
// Depends on tbar_pkg.
module tbar_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  valid_i,
   input  tbar_pkg::pix_type     black_blue,
   input  tbar_pkg::pix_type     black_green,
   input  tbar_pkg::pix_type     black_red,
   input  tbar_pkg::pix_type     white_blue,
   input  tbar_pkg::pix_type     white_green,
   input  tbar_pkg::pix_type     white_red,
   input  logic                  last_pixel,
   output logic                  valid_o,
   output tbar_pkg::div_type     data_o
);

   logic [tbar_pkg::NUM_CH-1:0][tbar_pkg::PIX_W-1:0] black_in;
   logic [tbar_pkg::NUM_CH-1:0][tbar_pkg::PIX_W-1:0] white_in;
   logic [tbar_pkg::NUM_CH-1:0][tbar_pkg::PIX_W-1:0] chan_alpha;
   logic [tbar_pkg::NUM_CH-1:0]                      chan_bad;

   // stage A: alpha sum
   logic                                             a_valid_ff;
   logic [tbar_pkg::SUM_W-1:0]                       a_sum_ff, a_sum_in;
   logic [tbar_pkg::NUM_CH-1:0][tbar_pkg::PIX_W-1:0] a_black_ff;
   logic                                             a_invalid_ff, a_invalid_in;
   logic                                             a_last_ff;

   // stage B: averaged alpha
   logic                                             b_valid_ff;
   logic [tbar_pkg::PROD_W-1:0]                      b_prod;
   logic [tbar_pkg::PIX_W-1:0]                       b_alpha_ff, b_alpha_in;
   logic [tbar_pkg::NUM_CH-1:0][tbar_pkg::PIX_W-1:0] b_black_ff;
   logic                                             b_invalid_ff;
   logic                                             b_last_ff;

   // stage C: divider setup
   logic                                             c_valid_ff;
   tbar_pkg::div_type                                c_data_ff, c_data_in;

   always_comb begin
      black_in[tbar_pkg::CH_BLUE]  = black_blue;
      black_in[tbar_pkg::CH_GREEN] = black_green;
      black_in[tbar_pkg::CH_RED]   = black_red;
      white_in[tbar_pkg::CH_BLUE]  = white_blue;
      white_in[tbar_pkg::CH_GREEN] = white_green;
      white_in[tbar_pkg::CH_RED]   = white_red;
      a_sum_in = '0;
      for (int ch = 0; ch < tbar_pkg::NUM_CH; ch++) begin
         chan_bad[ch] = white_in[ch] < black_in[ch];
         // difference counts as zero when white is below black
         chan_alpha[ch] = chan_bad[ch] ? tbar_pkg::PIX_MAX
                                       : tbar_pkg::PIX_MAX - (white_in[ch] - black_in[ch]);
         a_sum_in = a_sum_in + tbar_pkg::SUM_W'(chan_alpha[ch]);
      end
      a_invalid_in = |chan_bad;
   end

   // divide by three: multiply by reciprocal, exact over the sum's range
   always_comb begin
      b_prod = tbar_pkg::PROD_W'(a_sum_ff) * tbar_pkg::PROD_W'(tbar_pkg::RECIP3);
      b_alpha_in = tbar_pkg::PIX_W'(b_prod >> tbar_pkg::RECIP3_SHIFT);
   end

   // numerator 510*b + a, denominator 2*a
   always_comb begin
      c_data_in = '0;
      for (int ch = 0; ch < tbar_pkg::NUM_CH; ch++) begin
         c_data_in.rem[ch] = (tbar_pkg::REM_W'(b_black_ff[ch]) << 9)
                           - (tbar_pkg::REM_W'(b_black_ff[ch]) << 1)
                           + tbar_pkg::REM_W'(b_alpha_ff);
      end
      c_data_in.den     = {b_alpha_ff, 1'b0};
      c_data_in.black   = b_black_ff;
      c_data_in.alpha   = b_alpha_ff;
      c_data_in.invalid = b_invalid_ff;
      c_data_in.last    = b_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= valid_i;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_sum_ff     <= a_sum_in;
         a_black_ff   <= black_in;
         a_invalid_ff <= a_invalid_in;
         a_last_ff    <= last_pixel;
         b_alpha_ff   <= b_alpha_in;
         b_black_ff   <= a_black_ff;
         b_invalid_ff <= a_invalid_ff;
         b_last_ff    <= a_last_ff;
         c_data_ff    <= c_data_in;
      end
   end

   assign valid_o = c_valid_ff;
   assign data_o  = c_data_ff;

endmodule

// ===== rtl/tbar_cell.sv =====
// One restoring-division cell: settles one quotient bit for all three colors.
// Chained QUO_W times in the top level. Depends on tbar_pkg.
module tbar_cell #(
   parameter int BIT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              valid_i,
   input  tbar_pkg::div_type data_i,
   output logic              valid_o,
   output tbar_pkg::div_type data_o
);

   logic                        valid_ff;
   tbar_pkg::div_type           data_ff, data_in;
   logic [tbar_pkg::REM_W-1:0]  step;

   always_comb begin
      data_in = data_i;
      step    = tbar_pkg::REM_W'(data_i.den) << BIT;
      for (int ch = 0; ch < tbar_pkg::NUM_CH; ch++) begin
         if (data_i.rem[ch] >= step) begin
            data_in.rem[ch]      = data_i.rem[ch] - step;
            data_in.quo[ch][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule

// ===== rtl/two_background_alpha_recovery.sv =====
// Two-background alpha recovery, top level.
// Instantiates tbar_front and a chain of tbar_cell; depends on tbar_pkg.
//
// Takes a pixel seen over black and over white and returns the straight color
// and alpha, one result word per request word, in order. The block accepts a
// new word every cycle while req_stall is low. A word reaches rsp_valid
// through thirteen register stages, the first loaded at the edge that accepts
// it: three front stages (channel alpha and sum, divide-by-three by
// reciprocal, divider setup), nine divider cells that each settle one quotient
// bit of floor((510*black+alpha)/(2*alpha)) for all three colors at once, and
// the output register. The whole pipe moves as one;
// it halts only while a result word sits in the output register with
// rsp_stall high, so sustained throughput is one word per cycle. Quotients of
// 256 or more clamp to 255; zero alpha gives black colors of 0 and full alpha
// passes the black values through. pixel_invalid flags white below black in
// any channel. Two sticky flags follow the frame and give frame_ok on the word
// marked frame_end, after which they clear for the next frame.
module two_background_alpha_recovery (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  tbar_pkg::pix_type req_black_blue,
   input  tbar_pkg::pix_type req_black_green,
   input  tbar_pkg::pix_type req_black_red,
   input  tbar_pkg::pix_type req_white_blue,
   input  tbar_pkg::pix_type req_white_green,
   input  tbar_pkg::pix_type req_white_red,
   input  logic              req_last_pixel,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tbar_pkg::pix_type rsp_out_blue,
   output tbar_pkg::pix_type rsp_out_green,
   output tbar_pkg::pix_type rsp_out_red,
   output tbar_pkg::pix_type rsp_out_alpha,
   output logic              rsp_pixel_invalid,
   output logic              rsp_frame_end,
   output logic              rsp_frame_ok
);

   localparam int NCELL = tbar_pkg::QUO_W;

   logic              advance;
   logic              chain_valid [NCELL+1];
   tbar_pkg::div_type chain_data  [NCELL+1];

   tbar_pkg::div_type tail;
   logic [tbar_pkg::NUM_CH-1:0][tbar_pkg::PIX_W-1:0] color;
   logic              visible;
   logic              frame_ok;

   // output register and frame flags
   logic              rsp_valid_ff;
   logic [tbar_pkg::NUM_CH-1:0][tbar_pkg::PIX_W-1:0] color_ff;
   logic [tbar_pkg::PIX_W-1:0] alpha_ff;
   logic              invalid_ff;
   logic              last_ff;
   logic              ok_ff;
   logic              seen_visible_ff, seen_visible_in;
   logic              seen_invalid_ff, seen_invalid_in;

   // advance the whole pipe unless a result word is held by the consumer
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   tbar_front u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .valid_i     (req_valid),
      .black_blue  (req_black_blue),
      .black_green (req_black_green),
      .black_red   (req_black_red),
      .white_blue  (req_white_blue),
      .white_green (req_white_green),
      .white_red   (req_white_red),
      .last_pixel  (req_last_pixel),
      .valid_o     (chain_valid[0]),
      .data_o      (chain_data[0])
   );

   // divider chain, most significant quotient bit first
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      tbar_cell #(
         .BIT (NCELL - 1 - i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_i (chain_valid[i]),
         .data_i  (chain_data[i]),
         .valid_o (chain_valid[i+1]),
         .data_o  (chain_data[i+1])
      );
   end

   // clamp quotient, apply zero and full alpha cases
   always_comb begin
      tail = chain_data[NCELL];
      for (int ch = 0; ch < tbar_pkg::NUM_CH; ch++) begin
         if (tail.alpha == tbar_pkg::PIX_ZERO) begin
            color[ch] = tbar_pkg::PIX_ZERO;
         end else if (tail.alpha == tbar_pkg::PIX_MAX) begin
            color[ch] = tail.black[ch];
         end else if (tail.quo[ch][tbar_pkg::QUO_W-1]) begin
            color[ch] = tbar_pkg::PIX_MAX;
         end else begin
            color[ch] = tail.quo[ch][tbar_pkg::PIX_W-1:0];
         end
      end
      visible = (tail.alpha != tbar_pkg::PIX_ZERO) || (|color);
   end

   // frame verdict; flags clear after the last pixel
   always_comb begin
      seen_visible_in = seen_visible_ff || visible;
      seen_invalid_in = seen_invalid_ff || tail.invalid;
      frame_ok        = tail.last && seen_visible_in && !seen_invalid_in;
      if (tail.last) begin
         seen_visible_in = 1'b0;
         seen_invalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         seen_visible_ff <= 1'b0;
         seen_invalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain_valid[NCELL];
         if (chain_valid[NCELL]) begin
            seen_visible_ff <= seen_visible_in;
            seen_invalid_ff <= seen_invalid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         color_ff   <= color;
         alpha_ff   <= tail.alpha;
         invalid_ff <= tail.invalid;
         last_ff    <= tail.last;
         ok_ff      <= frame_ok;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_blue      = color_ff[tbar_pkg::CH_BLUE];
   assign rsp_out_green     = color_ff[tbar_pkg::CH_GREEN];
   assign rsp_out_red       = color_ff[tbar_pkg::CH_RED];
   assign rsp_out_alpha     = alpha_ff;
   assign rsp_pixel_invalid = invalid_ff;
   assign rsp_frame_end     = last_ff;
   assign rsp_frame_ok      = ok_ff;

endmodule

// ===== rtl/tbar_checker.sv =====
// Port-level checker for two_background_alpha_recovery, bound to the top level.
// Depends on tbar_pkg.
module tbar_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tbar_pkg::pix_type rsp_out_blue,
   input tbar_pkg::pix_type rsp_out_green,
   input tbar_pkg::pix_type rsp_out_red,
   input tbar_pkg::pix_type rsp_out_alpha,
   input logic              rsp_pixel_invalid,
   input logic              rsp_frame_end,
   input logic              rsp_frame_ok
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_blue)
         && $stable(rsp_out_alpha) && $stable(rsp_frame_end))
      else $error("stalled result word changed");

   // verdict only on the frame's last word
   a_ok_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok |-> rsp_frame_end)
      else $error("frame_ok outside frame end");

   // a frame-end word flagged invalid never carries frame_ok
   a_ok_not_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok |-> !rsp_pixel_invalid)
      else $error("frame_ok on invalid pixel");

   // zero alpha gives black colors
   a_zero_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_alpha == tbar_pkg::PIX_ZERO |->
         rsp_out_blue == tbar_pkg::PIX_ZERO && rsp_out_green == tbar_pkg::PIX_ZERO
         && rsp_out_red == tbar_pkg::PIX_ZERO)
      else $error("nonzero color at zero alpha");

endmodule

bind two_background_alpha_recovery tbar_checker u_tbar_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for two_background_alpha_recovery.
// Depends on tbar_pkg and the block's top level; drives pixel words, predicts the mattes.
module tb;

   // One pixel seen over both backgrounds, as offered on the request channel.
   typedef struct packed {
      tbar_pkg::pix_type black_blue;
      tbar_pkg::pix_type black_green;
      tbar_pkg::pix_type black_red;
      tbar_pkg::pix_type white_blue;
      tbar_pkg::pix_type white_green;
      tbar_pkg::pix_type white_red;
      logic              last_pixel;
   } pixel_type;

   // One recovered matte word, as seen on the response channel.
   typedef struct packed {
      tbar_pkg::pix_type blue;
      tbar_pkg::pix_type green;
      tbar_pkg::pix_type red;
      tbar_pkg::pix_type alpha;
      logic              invalid;
      logic              frame_end;
      logic              frame_ok;
   } matte_type;

   // Directed row: the pixel, whether the matte is typed in, and that matte.
   typedef struct packed {
      pixel_type px;
      logic      typed;
      matte_type want;
   } directed_row_type;

   localparam int NUM_DIRECTED  = 21;
   localparam int RANDOM_PIXELS = 600;
   localparam int HOLDOFF_LEN   = 80;
   localparam int TAIL_CYCLES   = 30;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   tbar_pkg::pix_type req_black_blue = '0;
   tbar_pkg::pix_type req_black_green = '0;
   tbar_pkg::pix_type req_black_red = '0;
   tbar_pkg::pix_type req_white_blue = '0;
   tbar_pkg::pix_type req_white_green = '0;
   tbar_pkg::pix_type req_white_red = '0;
   logic              req_last_pixel = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   tbar_pkg::pix_type rsp_out_blue;
   tbar_pkg::pix_type rsp_out_green;
   tbar_pkg::pix_type rsp_out_red;
   tbar_pkg::pix_type rsp_out_alpha;
   logic              rsp_pixel_invalid;
   logic              rsp_frame_end;
   logic              rsp_frame_ok;

   // Predictor copy of the per-frame sticky flags.
   logic frame_saw_visible = 1'b0;
   logic frame_saw_invalid = 1'b0;

   matte_type expected_mattes[$];
   int        mismatch_count = 0;
   int        mattes_checked = 0;
   int        pixels_sent = 0;
   int        frames_sent = 0;
   int        invalid_pixels = 0;
   int        ok_frames = 0;

   // Shared between stimulus and the receiver: quiet window and long hold-off.
   bit steady_run = 1'b0;
   bit holdoff_pending = 1'b0;

   // Directed pixels ((bb, bg, br, wb, wg, wr, last), typed, (blue, green, red, alpha,
   // invalid, end, ok)). Typed rows are read straight off the special cases.
   directed_row_type directed_rows [0:NUM_DIRECTED-1] = '{
      // zero alpha: pure black over black, pure white over white
      '{'{0, 0, 0, 255, 255, 255, 0}, 1, '{0, 0, 0, 0, 0, 0, 0}},
      // full alpha with black colors
      '{'{0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 255, 0, 0, 0}},
      // full alpha, colors pass through
      '{'{255, 255, 255, 255, 255, 255, 0}, 1, '{255, 255, 255, 255, 0, 0, 0}},
      // white below black in every channel: difference counts as zero
      '{'{255, 255, 255, 0, 0, 0, 0}, 1, '{255, 255, 255, 255, 1, 0, 0}},
      // frame end after an invalid pixel: verdict drops
      '{'{0, 0, 0, 255, 255, 255, 1}, 1, '{0, 0, 0, 0, 0, 1, 0}},
      // frame of one invisible pixel: nothing visible, no verdict
      '{'{0, 0, 0, 255, 255, 255, 1}, 1, '{0, 0, 0, 0, 0, 1, 0}},
      // clean visible frame of one pixel
      '{'{128, 128, 128, 128, 128, 128, 1}, 1, '{128, 128, 128, 255, 0, 1, 1}},
      // large quotient: blue clamps to 255
      '{'{200, 0, 0, 255, 255, 255, 0}, 0, '{0, 0, 0, 0, 0, 0, 0}},
      // alpha of one
      '{'{3, 0, 0, 255, 255, 255, 0}, 0, '{0, 0, 0, 0, 0, 0, 0}},
      // alpha truncates to zero while black is nonzero: colors still zero
      '{'{2, 0, 0, 255, 255, 255, 0}, 1, '{0, 0, 0, 0, 0, 0, 0}},
      '{'{100, 50, 25, 180, 170, 160, 0}, 0, '{0, 0, 0, 0, 0, 0, 0}},
      // white below black in one channel at a time
      '{'{10, 0, 0, 5, 255, 255, 0}, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{'{0, 10, 0, 255, 5, 255, 0}, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{'{0, 0, 10, 255, 255, 5, 0}, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{'{0, 0, 0, 255, 255, 255, 1}, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{'{1, 1, 1, 255, 255, 255, 0}, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{'{85, 170, 255, 200, 220, 255, 1}, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{'{255, 0, 128, 255, 255, 128, 0}, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{'{0, 255, 0, 255, 255, 255, 1}, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{'{127, 128, 129, 254, 253, 252, 0}, 0, '{0, 0, 0, 0, 0, 0, 0}},
      '{'{254, 1, 0, 255, 2, 1, 1}, 0, '{0, 0, 0, 0, 0, 0, 0}}
   };

   two_background_alpha_recovery uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_black_blue    (req_black_blue),
      .req_black_green   (req_black_green),
      .req_black_red     (req_black_red),
      .req_white_blue    (req_white_blue),
      .req_white_green   (req_white_green),
      .req_white_red     (req_white_red),
      .req_last_pixel    (req_last_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_blue      (rsp_out_blue),
      .rsp_out_green     (rsp_out_green),
      .rsp_out_red       (rsp_out_red),
      .rsp_out_alpha     (rsp_out_alpha),
      .rsp_pixel_invalid (rsp_pixel_invalid),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_frame_ok      (rsp_frame_ok)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Channel alpha: 255 minus the white-black difference, a negative
   // difference counting as zero.
   function automatic tbar_pkg::pix_type channel_alpha(input tbar_pkg::pix_type black,
                                                       input tbar_pkg::pix_type white);
      tbar_pkg::pix_type diff;
      diff = (white >= black) ? tbar_pkg::pix_type'(white - black) : tbar_pkg::PIX_ZERO;
      return tbar_pkg::PIX_MAX - diff;
   endfunction

   // Straight color: black*255/alpha rounded half up, clamped to 255.
   function automatic tbar_pkg::pix_type straight_color(input tbar_pkg::pix_type black,
                                                        input tbar_pkg::pix_type alpha);
      int quotient;
      if (alpha == tbar_pkg::PIX_ZERO) return tbar_pkg::PIX_ZERO;
      if (alpha == tbar_pkg::PIX_MAX) return black;
      quotient = (510 * int'(black) + int'(alpha)) / (2 * int'(alpha));
      return (quotient > 255) ? tbar_pkg::PIX_MAX : tbar_pkg::pix_type'(quotient);
   endfunction

   // Predict one matte and advance the frame flags.
   function automatic matte_type recover_pixel(input pixel_type px);
      logic [tbar_pkg::SUM_W-1:0] alpha_sum;
      matte_type m;
      alpha_sum = tbar_pkg::SUM_W'(channel_alpha(px.black_blue, px.white_blue))
                + tbar_pkg::SUM_W'(channel_alpha(px.black_green, px.white_green))
                + tbar_pkg::SUM_W'(channel_alpha(px.black_red, px.white_red));
      m.alpha     = tbar_pkg::pix_type'(alpha_sum / 3);
      m.blue      = straight_color(px.black_blue, m.alpha);
      m.green     = straight_color(px.black_green, m.alpha);
      m.red       = straight_color(px.black_red, m.alpha);
      m.invalid   = (px.white_blue < px.black_blue) || (px.white_green < px.black_green)
                 || (px.white_red < px.black_red);
      m.frame_end = px.last_pixel;
      m.frame_ok  = 1'b0;
      frame_saw_visible = frame_saw_visible || ((m.alpha | m.blue | m.green | m.red) != 0);
      frame_saw_invalid = frame_saw_invalid || m.invalid;
      if (px.last_pixel) begin
         m.frame_ok = frame_saw_visible && !frame_saw_invalid;
         frame_saw_visible = 1'b0;
         frame_saw_invalid = 1'b0;
      end
      return m;
   endfunction

   // Random pixel: mostly well-formed (white at or above black), then
   // transparent/opaque channels, all-extreme fields, and plain noise.
   function automatic pixel_type random_pixel();
      tbar_pkg::pix_type black [3];
      tbar_pkg::pix_type white [3];
      int                kind;
      pixel_type         px;
      kind = $urandom_range(99);
      for (int ch = 0; ch < 3; ch++) begin
         black[ch] = tbar_pkg::pix_type'($urandom);
         if (kind < 70) begin
            white[ch] = tbar_pkg::pix_type'(black[ch] + $urandom_range(0, 255 - black[ch]));
         end else if (kind < 80) begin
            if ($urandom_range(1)) begin
               black[ch] = tbar_pkg::PIX_ZERO;
               white[ch] = tbar_pkg::PIX_MAX;
            end else begin
               white[ch] = black[ch];
            end
         end else if (kind < 90) begin
            black[ch] = {tbar_pkg::PIX_W{1'($urandom_range(1))}};
            white[ch] = {tbar_pkg::PIX_W{1'($urandom_range(1))}};
         end else begin
            white[ch] = tbar_pkg::pix_type'($urandom);
         end
      end
      px.black_blue  = black[tbar_pkg::CH_BLUE];
      px.black_green = black[tbar_pkg::CH_GREEN];
      px.black_red   = black[tbar_pkg::CH_RED];
      px.white_blue  = white[tbar_pkg::CH_BLUE];
      px.white_green = white[tbar_pkg::CH_GREEN];
      px.white_red   = white[tbar_pkg::CH_RED];
      px.last_pixel  = 1'b0;
      return px;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at matte %0d: %s got %0d, expected %0d",
               mattes_checked, what, got, want);
      mismatch_count++;
   endtask

   // Offer one pixel word at a falling edge, hold it until accepted, then
   // queue its matte. Typed rows queue the typed matte; the predictor still
   // runs so the frame flags stay in step.
   task automatic offer_pixel(input pixel_type px, input bit typed,
                              input matte_type typed_matte);
      matte_type predicted;
      // idle now and then, except inside the quiet window
      while (!steady_run && $urandom_range(99) < 6) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_black_blue  <= px.black_blue;
      req_black_green <= px.black_green;
      req_black_red   <= px.black_red;
      req_white_blue  <= px.white_blue;
      req_white_green <= px.white_green;
      req_white_red   <= px.white_red;
      req_last_pixel  <= px.last_pixel;
      // hold the word until the block takes it
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = recover_pixel(px);
      expected_mattes.push_back(typed ? typed_matte : predicted);
      pixels_sent++;
      if (px.last_pixel) frames_sent++;
      if (predicted.invalid) invalid_pixels++;
      if (predicted.frame_ok) ok_frames++;
   endtask

   // Drop valid and wait until every queued matte has come back.
   task automatic drain_mattes();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_mattes.size() != 0) @(posedge clock);
   endtask

   // Receiver: random short stalls, a quiet window, and one long hold-off
   // counted here so the pipe fills and backs up onto the request side.
   initial begin
      int holdoff_left;
      holdoff_left = 0;
      forever begin
         @(negedge clock);
         if (holdoff_pending) begin
            holdoff_pending = 1'b0;
            holdoff_left = HOLDOFF_LEN;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else if (steady_run) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 6);
         end
      end
   end

   // Compare every accepted matte, field by field, with the oldest expectation.
   always @(posedge clock) begin
      matte_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_mattes.size() == 0) begin
            report_mismatch("unexpected matte word, count", 1, 0);
         end else begin
            want = expected_mattes.pop_front();
            if (rsp_out_blue !== want.blue)
               report_mismatch("blue", int'(rsp_out_blue), int'(want.blue));
            if (rsp_out_green !== want.green)
               report_mismatch("green", int'(rsp_out_green), int'(want.green));
            if (rsp_out_red !== want.red)
               report_mismatch("red", int'(rsp_out_red), int'(want.red));
            if (rsp_out_alpha !== want.alpha)
               report_mismatch("alpha", int'(rsp_out_alpha), int'(want.alpha));
            if (rsp_pixel_invalid !== want.invalid)
               report_mismatch("pixel_invalid", int'(rsp_pixel_invalid), int'(want.invalid));
            if (rsp_frame_end !== want.frame_end)
               report_mismatch("frame_end", int'(rsp_frame_end), int'(want.frame_end));
            if (rsp_frame_ok !== want.frame_ok)
               report_mismatch("frame_ok", int'(rsp_frame_ok), int'(want.frame_ok));
         end
         mattes_checked++;
      end
   end

   // Stimulus: reset, directed rows, then random frames.
   initial begin
      pixel_type px;
      int        frame_len;
      int        random_sent;
      random_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int row = 0; row < NUM_DIRECTED; row++) begin
         offer_pixel(directed_rows[row].px, directed_rows[row].typed, directed_rows[row].want);
      end
      // pause the sender until the directed mattes are all back
      drain_mattes();

      while (random_sent < RANDOM_PIXELS) begin
         frame_len = $urandom_range(1, 12);
         for (int k = 0; k < frame_len; k++) begin
            px = random_pixel();
            // well-formed frames end on their last pixel; a few stray marks as noise
            px.last_pixel = (k == frame_len - 1) || ($urandom_range(99) < 3);
            if (random_sent == 100) holdoff_pending = 1'b1;
            steady_run = (random_sent >= 300) && (random_sent < 420);
            offer_pixel(px, 1'b0, '0);
            random_sent++;
         end
         if (random_sent >= 480 && random_sent < 480 + frame_len) drain_mattes();
      end
      steady_run = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      // wait out the pipe, then a few more cycles for any stray word
      while (expected_mattes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d pixels in %0d frames (%0d invalid, %0d frames judged ok)",
               pixels_sent, frames_sent, invalid_pixels, ok_frames);
      $display("checked %0d mattes, %0d mismatches", mattes_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("two_background_alpha_recovery test passed");
      end else begin
         $display("two_background_alpha_recovery test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("timeout with %0d mattes outstanding", expected_mattes.size());
      $display("two_background_alpha_recovery test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tbar_pkg.sv
rtl/tbar_front.sv
rtl/tbar_cell.sv
rtl/two_background_alpha_recovery.sv
rtl/tbar_checker.sv
test/tb.sv
